// ===== sv/heat_diffusion_stencil_3x3_assert.svh =====
//------------------------------------------------------------------------------
// Assertion macros for the heat diffusion stencil
// Clocked assertion wrappers. Defining NO_ASSERTIONS removes them all.
//------------------------------------------------------------------------------
`ifndef HEAT_DIFFUSION_STENCIL_3X3_ASSERT_SVH
`define HEAT_DIFFUSION_STENCIL_3X3_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Property holds on every edge out of reset.
`define HDS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Consequent holds on the edge after the antecedent.
`define HDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HDS_ASSERT(lbl, clk, rst_n, prop, msg)
`define HDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== sv/hds_pkg.sv =====
//------------------------------------------------------------------------------
// hds_pkg
// Shared types and constants of the heat diffusion stencil.
//------------------------------------------------------------------------------
package hds_pkg;

    localparam int MAX_COLS_DEF = 1024;
    localparam int MAX_ROWS_DEF = 4096;

    localparam int TEMP_W     = 32;           // Q24.8
    localparam int PAIR_W     = TEMP_W + 1;
    localparam int QUAD_W     = TEMP_W + 2;
    localparam int SUM_W      = TEMP_W + 3;   // sum of 8 neighbors
    localparam int GAIN_W     = 16;           // Q0.16
    localparam int PROD_SHIFT = 19;           // mean (1/8) times Q0.16 gain
    localparam int WIN_N      = 6;

    localparam int COLS_W    = 11;
    localparam int ROWS_W    = 13;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int MIN_DIM   = 3;
    localparam int COLS_RST  = 512;
    localparam int ROWS_RST  = 506;
    localparam int GAIN_RST  = 16384;

    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 2'd2;

    localparam int OFIFO_DEPTH = 16;

    typedef struct packed {
        logic              mode;
        logic [TEMP_W-1:0] temperature;
    } t_hds_in;

    typedef struct packed {
        logic [TEMP_W-1:0] new_temperature;
        logic              last_of_frame;
    } t_hds_out;

    // Window taps handed from the line buffer to the update pipe
    typedef struct packed {
        logic [3:0][PAIR_W-1:0] pair;
        logic [TEMP_W-1:0]      center;
        logic                   interior;
        logic                   last;
    } t_hds_taps;

endpackage

// ===== sv/hds_ram.sv =====
//------------------------------------------------------------------------------
// hds_ram
// Simple dual-port RAM, one write and one registered read per cycle.
//------------------------------------------------------------------------------
module hds_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 1024,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AddrW-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/hds_linebuf.sv =====
//------------------------------------------------------------------------------
// hds_linebuf
// Raster counters, line store RAM with forwarding, and the 3x3 window.
//------------------------------------------------------------------------------
`include "heat_diffusion_stencil_3x3_assert.svh"

module hds_linebuf #(
    parameter int  MAX_COLS = hds_pkg::MAX_COLS_DEF,
    parameter int  MAX_ROWS = hds_pkg::MAX_ROWS_DEF,
    localparam int ColW     = $clog2(MAX_COLS + 1),
    localparam int NrW      = $clog2(MAX_ROWS + 1),
    localparam int TotW     = $clog2(MAX_COLS * MAX_ROWS + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_restart,
    input  logic [ColW-1:0]                i_nc,
    input  logic [NrW-1:0]                 i_nr,
    input  logic [TotW-1:0]                i_total,
    input  logic                           i_accept,
    input  logic [hds_pkg::TEMP_W-1:0]     i_temp,
    output logic                           o_emit,
    output logic                           o_tap_valid,
    output hds_pkg::t_hds_taps             o_taps
);

    import hds_pkg::*;

    localparam int AddrW = $clog2(MAX_COLS);
    localparam int RowW  = $clog2(MAX_ROWS + 2);
    localparam int IdxW  = $clog2(MAX_COLS * MAX_ROWS);

    logic [AddrW-1:0]  r_in_col;
    logic [RowW-1:0]   r_in_row;
    logic [IdxW-1:0]   r_out_idx;

    logic              emit, last, interior, frame_done;
    logic [ColW-1:0]   col_inc;

    // stage B: RAM data arrives
    logic              r_b_valid, r_b_emit, r_b_interior, r_b_last, r_b_restart;
    logic [AddrW-1:0]  r_b_col;
    logic [TEMP_W-1:0] r_b_t;
    logic              r_fwd;
    logic [TEMP_W-1:0] r_fwd_up, r_fwd_mid;

    logic [2*TEMP_W-1:0] rd_data;
    logic [TEMP_W-1:0]   up, mid;
    logic [TEMP_W-1:0]   r_win [WIN_N];

    logic                r_tap_valid;
    t_hds_taps           r_taps;

    // position decode
    always_comb begin
        col_inc    = ColW'(r_in_col) + ColW'(1);
        emit       = (r_in_row >= RowW'(2) || (r_in_row == RowW'(1) && r_in_col != '0))
                     && (TotW'(r_out_idx) < i_total);
        last       = (TotW'(r_out_idx) + TotW'(1)) == i_total;
        interior   = (r_in_row >= RowW'(2)) && (r_in_row <= RowW'(i_nr) - RowW'(1))
                     && (r_in_col >= AddrW'(2)) && (ColW'(r_in_col) <= i_nc - ColW'(1));
        frame_done = emit && last;
    end

    assign o_emit = emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_idx <= '0;
        end else if (i_accept) begin
            if (frame_done) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_idx <= '0;
            end else begin
                if (col_inc >= i_nc) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + RowW'(1);
                end else begin
                    r_in_col <= AddrW'(col_inc);
                end
                if (emit) begin
                    r_out_idx <= r_out_idx + IdxW'(1);
                end
            end
        end
    end

    // upper row in the high half, middle row in the low half
    hds_ram #(
        .WIDTH (2 * TEMP_W),
        .DEPTH (MAX_COLS)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (r_b_valid),
        .i_waddr (r_b_col),
        .i_wdata ({mid, r_b_t}),
        .i_re    (i_accept),
        .i_raddr (r_in_col),
        .o_rdata (rd_data)
    );

    // same column read while it is being written: take the write data
    assign up  = r_fwd ? r_fwd_up  : rd_data[2*TEMP_W-1:TEMP_W];
    assign mid = r_fwd ? r_fwd_mid : rd_data[TEMP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_fwd     <= 1'b0;
        end else begin
            r_b_valid <= i_accept;
            if (i_accept) begin
                r_fwd <= r_b_valid && (r_b_col == r_in_col);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_b_col      <= r_in_col;
            r_b_t        <= i_temp;
            r_b_emit     <= emit;
            r_b_interior <= interior;
            r_b_last     <= last;
            r_b_restart  <= frame_done;
            r_fwd_up     <= mid;
            r_fwd_mid    <= r_b_t;
        end
    end

    // window: 0..2 two columns back, 3..5 one column back (upper, middle, lower)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            for (int i = 0; i < WIN_N; i++) begin
                r_win[i] <= '0;
            end
        end else if (r_b_valid) begin
            if (r_b_restart) begin
                for (int i = 0; i < WIN_N; i++) begin
                    r_win[i] <= '0;
                end
            end else begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= up;
                r_win[4] <= mid;
                r_win[5] <= r_b_t;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_valid <= 1'b0;
        end else begin
            r_tap_valid <= r_b_valid && r_b_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_taps.pair[0]  <= PAIR_W'(r_win[0]) + PAIR_W'(r_win[1]);
            r_taps.pair[1]  <= PAIR_W'(r_win[2]) + PAIR_W'(r_win[3]);
            r_taps.pair[2]  <= PAIR_W'(r_win[5]) + PAIR_W'(up);
            r_taps.pair[3]  <= PAIR_W'(mid) + PAIR_W'(r_b_t);
            r_taps.center   <= r_win[4];
            r_taps.interior <= r_b_interior;
            r_taps.last     <= r_b_last;
        end
    end

    assign o_tap_valid = r_tap_valid;
    assign o_taps      = r_taps;

    `HDS_ASSERT(a_col_in_grid, i_clk, i_rst_n, ColW'(r_in_col) < i_nc,
        "column counter beyond grid width")
    `HDS_ASSERT_NEXT(a_frame_restart, i_clk, i_rst_n, i_accept && frame_done,
        r_in_col == '0 && r_in_row == '0 && r_out_idx == '0,
        "counters not cleared after last word of frame")

endmodule

// ===== sv/hds_update.sv =====
//------------------------------------------------------------------------------
// hds_update
// Diffusion update c + k*(mean - c), adder tree, multiply and final add.
//------------------------------------------------------------------------------
module hds_update (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [hds_pkg::GAIN_W-1:0]  i_gain,
    input  logic                        i_tap_valid,
    input  hds_pkg::t_hds_taps          i_taps,
    output logic                        o_valid,
    output hds_pkg::t_hds_out           o_word
);

    import hds_pkg::*;

    localparam int ProdW = SUM_W + GAIN_W;

    logic                    r_c_valid, r_d_valid, r_e_valid, r_f_valid;
    logic [QUAD_W-1:0]       r_q0, r_q1;
    logic [SUM_W-1:0]        r_sum;
    logic [SUM_W-1:0]        r_diff;
    logic                    r_e_neg, r_f_neg;
    logic [TEMP_W-1:0]       r_delta;
    logic [TEMP_W-1:0]       r_c_cen, r_d_cen, r_e_cen, r_f_cen;
    logic                    r_c_int, r_d_int, r_e_int, r_f_int;
    logic                    r_c_last, r_d_last, r_e_last, r_f_last;

    logic [SUM_W-1:0]        c8;
    logic [ProdW-1:0]        prod;
    logic [TEMP_W-1:0]       res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
        end else begin
            r_c_valid <= i_tap_valid;
            r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid;
            r_f_valid <= r_e_valid;
        end
    end

    assign c8   = {r_d_cen, 3'b000};
    assign prod = ProdW'(r_diff) * ProdW'(i_gain);

    always_ff @(posedge i_clk) begin
        // C: two quad sums
        r_q0     <= QUAD_W'(i_taps.pair[0]) + QUAD_W'(i_taps.pair[1]);
        r_q1     <= QUAD_W'(i_taps.pair[2]) + QUAD_W'(i_taps.pair[3]);
        r_c_cen  <= i_taps.center;
        r_c_int  <= i_taps.interior;
        r_c_last <= i_taps.last;
        // D: neighbor sum
        r_sum    <= SUM_W'(r_q0) + SUM_W'(r_q1);
        r_d_cen  <= r_c_cen;
        r_d_int  <= r_c_int;
        r_d_last <= r_c_last;
        // E: |sum - 8c| and its sign
        r_e_neg  <= r_sum < c8;
        r_diff   <= (r_sum < c8) ? (c8 - r_sum) : (r_sum - c8);
        r_e_cen  <= r_d_cen;
        r_e_int  <= r_d_int;
        r_e_last <= r_d_last;
        // F: scaled step, truncated toward zero
        r_delta  <= prod[PROD_SHIFT +: TEMP_W];
        r_f_neg  <= r_e_neg;
        r_f_cen  <= r_e_cen;
        r_f_int  <= r_e_int;
        r_f_last <= r_e_last;
    end

    // result stays between c and the mean, no wrap
    assign res = r_f_neg ? (r_f_cen - r_delta) : (r_f_cen + r_delta);

    assign o_valid                = r_f_valid;
    assign o_word.new_temperature = r_f_int ? res : '0;
    assign o_word.last_of_frame   = r_f_last;

endmodule

// ===== sv/hds_ofifo.sv =====
//------------------------------------------------------------------------------
// hds_ofifo
// Output word queue between the update pipe and the output channel.
//------------------------------------------------------------------------------
`include "heat_diffusion_stencil_3x3_assert.svh"

module hds_ofifo #(
    parameter int DEPTH = hds_pkg::OFIFO_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  hds_pkg::t_hds_out i_word,
    input  logic              i_pop,
    output logic              o_valid,
    output hds_pkg::t_hds_out o_word
);

    import hds_pkg::*;

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    t_hds_out        r_mem [DEPTH];
    logic [PtrW-1:0] r_head, r_tail;
    logic [CntW-1:0] r_count;
    logic            pop;

    assign o_valid = r_count != '0;
    assign o_word  = r_mem[r_head];
    assign pop     = o_valid && i_pop;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= (r_tail == PtrW'(DEPTH - 1)) ? '0 : r_tail + PtrW'(1);
            end
            if (pop) begin
                r_head <= (r_head == PtrW'(DEPTH - 1)) ? '0 : r_head + PtrW'(1);
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + CntW'(1);
                2'b01:   r_count <= r_count - CntW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `HDS_ASSERT(a_no_overflow, i_clk, i_rst_n, !i_push || r_count < CntW'(DEPTH),
        "word pushed into full output queue")

endmodule

// ===== sv/heat_diffusion_stencil_3x3.sv =====
//------------------------------------------------------------------------------
// heat_diffusion_stencil_3x3
// One Jacobi step of 2D heat diffusion on a raster-order grid stream.
//------------------------------------------------------------------------------
// Cells (unsigned Q24.8) enter one word per cycle in raster order. Each
// interior cell c becomes c + k*(s - c), s the mean of its 8 neighbors,
// k the Q0.16 gain, truncated toward zero; border cells come out zero. The
// output stream trails the input by one row plus one cell, so cols+1 flush
// words (mode = 1, treated as zero cells) drain the end of a grid; the
// final cell carries last_of_frame, and the next word starts a new frame.
// Rate: one word per cycle while the output channel takes words. A word
// passes stage B and the tap register in the line buffer, then update
// stages C to F, before the output queue; the previous and current grid
// rows sit in one 64-bit line store RAM, read once, written once per word.
// Input ready drops when 16 result words are outstanding (in flight or
// queued), and for one cycle after reset or any register write while the
// grid size product settles. A write to cols, rows or gain restarts the
// frame; write only while the block is idle.
//------------------------------------------------------------------------------
`include "heat_diffusion_stencil_3x3_assert.svh"

module heat_diffusion_stencil_3x3 #(
    parameter int MAX_COLS = hds_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = hds_pkg::MAX_ROWS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input word channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  hds_pkg::t_hds_in                 i_in_data,
    // output word channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output hds_pkg::t_hds_out                o_out_data,
    // register writes
    input  logic                             i_cfg_we,
    input  logic [hds_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [hds_pkg::CFG_W-1:0]        i_cfg_wdata
);

    import hds_pkg::*;

    localparam int ColW  = $clog2(MAX_COLS + 1);
    localparam int NrW   = $clog2(MAX_ROWS + 1);
    localparam int TotW  = $clog2(MAX_COLS * MAX_ROWS + 1);
    localparam int UsedW = $clog2(OFIFO_DEPTH + 1);

    function automatic int clamp_dim(input int v, input int hi);
        int r;
        r = v;
        if (v < MIN_DIM) begin
            r = MIN_DIM;
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

    // configuration, stored already clamped
    logic [ColW-1:0]   r_nc;
    logic [NrW-1:0]    r_nr;
    logic [GAIN_W-1:0] r_gain;
    logic [TotW-1:0]   r_total;
    logic              r_cfg_busy;
    logic              restart;

    // flow control
    logic [UsedW-1:0]  r_used;
    logic [UsedW-1:0]  n_used;
    logic              in_accept, out_pop, emit;
    logic [TEMP_W-1:0] in_temp;

    logic              tap_valid;
    t_hds_taps         taps;
    logic              upd_valid;
    t_hds_out          upd_word;

    assign restart = i_cfg_we &&
                     (i_cfg_idx == CFG_COLS || i_cfg_idx == CFG_ROWS || i_cfg_idx == CFG_GAIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nc       <= ColW'(clamp_dim(COLS_RST, MAX_COLS));
            r_nr       <= NrW'(clamp_dim(ROWS_RST, MAX_ROWS));
            r_gain     <= GAIN_W'(GAIN_RST);
            r_cfg_busy <= 1'b1;
        end else begin
            r_cfg_busy <= i_cfg_we;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_COLS: r_nc   <= ColW'(clamp_dim(int'(i_cfg_wdata[COLS_W-1:0]),
                                                        MAX_COLS));
                    CFG_ROWS: r_nr   <= NrW'(clamp_dim(int'(i_cfg_wdata[ROWS_W-1:0]),
                                                       MAX_ROWS));
                    CFG_GAIN: r_gain <= i_cfg_wdata[GAIN_W-1:0];
                    default:  ;
                endcase
            end
        end
    end

    // grid size; settles during the busy cycle after a write
    always_ff @(posedge i_clk) begin
        r_total <= TotW'({{NrW{1'b0}}, r_nc} * {{ColW{1'b0}}, r_nr});
    end

    // one slot reserved per result word from acceptance until it leaves
    assign o_in_ready = !r_cfg_busy && (r_used < UsedW'(OFIFO_DEPTH));
    assign in_accept  = i_in_valid && o_in_ready;
    assign out_pop    = o_out_valid && i_out_ready;
    assign in_temp    = i_in_data.mode ? '0 : i_in_data.temperature;

    always_comb begin
        case ({in_accept && emit, out_pop})
            2'b10:   n_used = r_used + UsedW'(1);
            2'b01:   n_used = r_used - UsedW'(1);
            default: n_used = r_used;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= n_used;
        end
    end

    hds_linebuf #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_linebuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (restart),
        .i_nc        (r_nc),
        .i_nr        (r_nr),
        .i_total     (r_total),
        .i_accept    (in_accept),
        .i_temp      (in_temp),
        .o_emit      (emit),
        .o_tap_valid (tap_valid),
        .o_taps      (taps)
    );

    hds_update u_update (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_gain      (r_gain),
        .i_tap_valid (tap_valid),
        .i_taps      (taps),
        .o_valid     (upd_valid),
        .o_word      (upd_word)
    );

    hds_ofifo #(
        .DEPTH (OFIFO_DEPTH)
    ) u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (upd_valid),
        .i_word  (upd_word),
        .i_pop   (i_out_ready),
        .o_valid (o_out_valid),
        .o_word  (o_out_data)
    );

    `HDS_ASSERT(a_used_bounded, i_clk, i_rst_n, r_used <= UsedW'(OFIFO_DEPTH),
        "reserved output slots exceed queue depth")
    `HDS_ASSERT(a_out_reserved, i_clk, i_rst_n, !o_out_valid || r_used != '0,
        "output word without a reserved slot")

endmodule
